FILE: hdl/pdu_pkg.sv
package pdu_pkg;

	localparam int MAX_UTF8_BYTES = 4;
	localparam int BUF_DEPTH      = 3 * MAX_UTF8_BYTES;
	localparam int CP_W           = 21;
	localparam int TDATA_W        = ((CP_W + 7) / 8) * 8;
	localparam int CNT_W          = $clog2(BUF_DEPTH + 1);
	localparam int IDX_W          = $clog2(BUF_DEPTH);
	localparam int TRI_W          = $clog2(MAX_UTF8_BYTES);
	localparam int LEN_W          = 3;

	typedef logic [CP_W-1:0]  cp_t;
	typedef logic [7:0]       oct_t;
	typedef logic [LEN_W-1:0] len_t;

	localparam cp_t CH_PCT    = 21'h00_0025;
	localparam cp_t CH_QMARK  = 21'h00_003F;
	localparam cp_t CH_SLASH  = 21'h00_002F;
	localparam cp_t CH_BSLASH = 21'h00_005C;
	localparam cp_t SURR_BASE = 21'h00_DC80;

	// result of the shared escape decoder
	typedef struct packed {
		logic ok;
		oct_t val;
	} esc_t;

	// result of the UTF-8 assembler
	typedef struct packed {
		logic ok;
		cp_t  cp;
	} utf8_res_t;

	// sequence length implied by a lead byte; 1 when it is no usable lead
	function automatic len_t lead_len(input oct_t b);
		len_t len;
		len = len_t'(1);
		if ((b & 8'hE0) == 8'hC0)      len = len_t'(2);
		else if ((b & 8'hF0) == 8'hE0) len = len_t'(3);
		else if ((b & 8'hF8) == 8'hF0) len = len_t'(4);
		else if ((b & 8'hFC) == 8'hF8) len = len_t'(5);
		else if ((b & 8'hFE) == 8'hFC) len = len_t'(6);
		if (int'(len) > MAX_UTF8_BYTES) len = len_t'(1);
		return len;
	endfunction

endpackage

FILE: hdl/percent_decode_utf8_path.sv
// channel   | dir | signals                                   | accepted when
// ----------+-----+-------------------------------------------+------------------------
// s         | in  | s_tvalid s_tready s_tdata s_tlast         | s_tvalid && s_tready
// m         | out | m_tvalid m_tready m_tdata m_tlast         | m_tvalid && m_tready
// cfg       | in  | cfg_valid cfg_ready cfg_data              | cfg_valid && cfg_ready
//
// An item is loaded, then the sequencer works through its head decisions (each result,
// each wait check), scans each continuation escape and assembles a multi-byte code
// point; a '/' inserted at path start is one more step.
// The shared escape decoder and the single output register set the pace of these steps.
// s_tready is high only while the sequencer is idle; a stalled m side holds it.
// arst_n clears control state; buffer contents are not reset.
module percent_decode_utf8_path (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [pdu_pkg::TDATA_W-1:0]   s_tdata,  // [20:0] char_in, rest zero
	input  logic                          s_tlast,  // in_last
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [pdu_pkg::TDATA_W-1:0]   m_tdata,  // [20:0] char_out, rest zero
	output logic                          m_tlast,  // out_last
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic                          cfg_data  // force_leading_slash
);
	import pdu_pkg::*;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_HEAD = 2'd1;
	localparam logic [1:0] ST_SCAN = 2'd2;
	localparam logic [1:0] ST_DEC  = 2'd3;

	logic [1:0]                      state_q, nstate;
	logic [BUF_DEPTH-1:0][CP_W-1:0]  buf_q;
	logic [CNT_W-1:0]                cnt_q;
	logic                            end_q;
	logic                            start_q;
	logic                            force_q;
	logic [TRI_W-1:0]                k_q, k_n;
	len_t                            len_q, len_n;
	oct_t                            ub_q [MAX_UTF8_BYTES];
	logic                            m_tvalid_q;
	cp_t                             odata_q;
	logic                            olast_q;

	logic [TRI_W-1:0]                tri_sel;
	logic [IDX_W-1:0]                base;
	esc_t                            esc;
	utf8_res_t                       u8;
	oct_t                            lead;
	cp_t                             inv_c;
	logic                            emit;
	cp_t                             emit_c;
	logic [CNT_W-1:0]                drop;
	logic                            cap0;
	logic                            capk;
	logic                            slash;
	logic                            out_free;
	logic                            load;
	logic                            step;
	logic                            s_acc;

	// shared escape decoder looks at triplet 0 or at the continuation being scanned
	assign tri_sel = (state_q == ST_SCAN) ? k_q : '0;
	assign base    = IDX_W'(3 * int'(tri_sel));

	pdu_esc u_esc (
		.c0  (buf_q[base]),
		.c1  (buf_q[IDX_W'(base + IDX_W'(1))]),
		.c2  (buf_q[IDX_W'(base + IDX_W'(2))]),
		.res (esc)
	);

	pdu_utf8 u_utf8 (
		.bytes_q (ub_q),
		.len     (len_q),
		.res     (u8)
	);

	assign lead  = (state_q == ST_HEAD) ? esc.val : ub_q[0];
	assign inv_c = SURR_BASE + cp_t'(lead);

	always_comb begin
		nstate = state_q;
		k_n    = k_q;
		len_n  = len_q;
		emit   = 1'b0;
		emit_c = '0;
		drop   = '0;
		cap0   = 1'b0;
		capk   = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				nstate = ST_IDLE;
			end
			ST_HEAD: begin
				priority if (cnt_q == '0) begin
					nstate = ST_IDLE;
				end else if (buf_q[0] != CH_PCT) begin
					emit = 1'b1; emit_c = buf_q[0]; drop = CNT_W'(1);
				end else if (cnt_q < CNT_W'(3)) begin
					if (!end_q) begin
						nstate = ST_IDLE;
					end else begin
						emit = 1'b1; emit_c = CH_PCT; drop = CNT_W'(1);
					end
				end else if (!esc.ok) begin
					emit = 1'b1; emit_c = CH_PCT; drop = CNT_W'(1);
				end else if (!esc.val[7]) begin
					emit = 1'b1; emit_c = cp_t'(esc.val); drop = CNT_W'(3);
				end else if (lead_len(esc.val) < len_t'(2)) begin
					emit = 1'b1; emit_c = inv_c; drop = CNT_W'(3);
				end else begin
					cap0   = 1'b1;
					len_n  = lead_len(esc.val);
					k_n    = TRI_W'(1);
					nstate = ST_SCAN;
				end
			end
			ST_SCAN: begin
				priority if (CNT_W'(3 * int'(k_q) + 3) > cnt_q) begin
					if (!end_q) begin
						nstate = ST_IDLE;
					end else begin
						emit = 1'b1; emit_c = inv_c; drop = CNT_W'(3); nstate = ST_HEAD;
					end
				end else if (!esc.ok) begin
					emit = 1'b1; emit_c = inv_c; drop = CNT_W'(3); nstate = ST_HEAD;
				end else begin
					capk = 1'b1;
					if (len_t'(k_q) == len_q - len_t'(1)) nstate = ST_DEC;
					else k_n = k_q + TRI_W'(1);
				end
			end
			ST_DEC: begin
				emit   = 1'b1;
				nstate = ST_HEAD;
				if (u8.ok) begin
					emit_c = u8.cp;
					drop   = CNT_W'(3 * int'(len_q));
				end else begin
					emit_c = inv_c;
					drop   = CNT_W'(3);
				end
			end
			default: nstate = ST_IDLE;
		endcase
	end

	// '/' goes out first without consuming anything; the same decision repeats next cycle
	assign slash    = emit && start_q && force_q && emit_c != CH_SLASH && emit_c != CH_BSLASH;
	assign out_free = !m_tvalid_q || m_tready;
	assign load     = emit && out_free;
	assign step     = (!emit || out_free) && !slash;
	assign s_acc    = s_tvalid && s_tready;

	assign s_tready  = (state_q == ST_IDLE);
	assign cfg_ready = 1'b1;
	assign m_tvalid  = m_tvalid_q;
	assign m_tdata   = TDATA_W'(odata_q);
	assign m_tlast   = olast_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			cnt_q      <= '0;
			end_q      <= 1'b0;
			start_q    <= 1'b1;
			force_q    <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) force_q <= cfg_data;
			if (load) m_tvalid_q <= 1'b1;
			else if (m_tready) m_tvalid_q <= 1'b0;
			if (load) start_q <= 1'b0;
			else if (state_q == ST_HEAD && cnt_q == '0 && end_q) start_q <= 1'b1;
			if (s_acc) begin
				state_q <= ST_HEAD;
				end_q   <= s_tlast;
				if (cnt_q < CNT_W'(BUF_DEPTH)) cnt_q <= cnt_q + CNT_W'(1);
			end else if (step) begin
				state_q <= nstate;
				cnt_q   <= cnt_q - drop;
			end
		end
	end

	// an item only arrives while idle, when the sequencer changes nothing here
	always_ff @(posedge clk) begin
		if (s_acc) begin
			if (cnt_q < CNT_W'(BUF_DEPTH)) buf_q[cnt_q[IDX_W-1:0]] <= s_tdata[CP_W-1:0];
		end else if (step) begin
			buf_q <= buf_q >> (int'(drop) * CP_W);
			k_q   <= k_n;
			len_q <= len_n;
			if (cap0) ub_q[0] <= esc.val;
			if (capk) ub_q[k_q] <= esc.val;
		end
		if (load) begin
			odata_q <= slash ? CH_SLASH : emit_c;
			olast_q <= !slash && end_q && (cnt_q == drop);
		end
	end

endmodule

FILE: hdl/pdu_esc.sv
module pdu_esc (
	input  pdu_pkg::cp_t  c0,
	input  pdu_pkg::cp_t  c1,
	input  pdu_pkg::cp_t  c2,
	output pdu_pkg::esc_t res
);
	import pdu_pkg::*;

	function automatic logic [4:0] hex_val(input cp_t c);
		logic [4:0] r;
		r = 5'h10; // bit 4 marks "not a hex digit"
		if (c >= 21'h30 && c <= 21'h39)      r = {1'b0, 4'(c - 21'h30)};
		else if (c >= 21'h61 && c <= 21'h66) r = {1'b0, 4'(c - 21'h57)};
		else if (c >= 21'h41 && c <= 21'h46) r = {1'b0, 4'(c - 21'h37)};
		return r;
	endfunction

	logic [4:0] hi;
	logic [4:0] lo;
	oct_t       raw;

	always_comb begin
		hi      = hex_val(c1);
		lo      = hex_val(c2);
		raw     = {hi[3:0], lo[3:0]};
		res.ok  = (c0 == CH_PCT) && !hi[4] && !lo[4];
		res.val = (raw == 8'h00) ? CH_QMARK[7:0] : raw;
	end

endmodule

FILE: hdl/pdu_utf8.sv
module pdu_utf8 (
	input  pdu_pkg::oct_t      bytes_q [pdu_pkg::MAX_UTF8_BYTES],
	input  pdu_pkg::len_t      len,
	output pdu_pkg::utf8_res_t res
);
	import pdu_pkg::*;

	cp_t  v2;
	cp_t  v3;
	cp_t  v4;
	logic c1;
	logic c2;
	logic c3;

	always_comb begin
		v2 = {10'b0, bytes_q[0][4:0], bytes_q[1][5:0]};
		v3 = {5'b0, bytes_q[0][3:0], bytes_q[1][5:0], bytes_q[2][5:0]};
		v4 = {bytes_q[0][2:0], bytes_q[1][5:0], bytes_q[2][5:0], bytes_q[3][5:0]};
		c1 = (bytes_q[1][7:6] == 2'b10);
		c2 = (bytes_q[2][7:6] == 2'b10);
		c3 = (bytes_q[3][7:6] == 2'b10);
		res.ok = 1'b0;
		res.cp = v4;
		unique case (len)
			len_t'(2): begin
				res.ok = c1 && (v2 >= 21'h80);
				res.cp = v2;
			end
			len_t'(3): begin
				// surrogate range is refused
				res.ok = c1 && c2 && (v3 >= 21'h800) && !(v3 >= 21'hD800 && v3 <= 21'hDFFF);
				res.cp = v3;
			end
			len_t'(4): begin
				res.ok = c1 && c2 && c3 && (v4 >= 21'h1_0000) && (v4 <= 21'h10_FFFF);
				res.cp = v4;
			end
			default: begin
				res.ok = 1'b0;
				res.cp = v4;
			end
		endcase
	end

endmodule

FILE: hdl/pdu_chk.sv
module pdu_chk (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        s_tvalid,
	input logic                        s_tready,
	input logic                        m_tvalid,
	input logic                        m_tready,
	input logic [pdu_pkg::TDATA_W-1:0] m_tdata,
	input logic                        m_tlast
);
	import pdu_pkg::*;

	// an accepted item keeps the sequencer busy in the following cycle
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input taken twice in a row");

	// a fresh result is only produced while an item is being worked on
	a_new_result_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> !s_tready)
		else $error("result appeared while idle");

	a_pad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[TDATA_W-1:CP_W] == '0)
		else $error("tdata padding not zero");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("stalled item changed");

endmodule

bind percent_decode_utf8_path pdu_chk u_pdu_chk (.*);
